/* design/sh24_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_pkg
// Shared types, constants and SipHash helper functions for the stream hasher.
// ----------------------------------------------------------------------------
package sh24_pkg;

    localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
    localparam logic [63:0] SIP_FINAL_XOR = 64'h00000000000000ff;
    localparam logic [63:0] MASK24 = 64'h0000000000FFFFFF;
    localparam logic [63:0] MASK32 = 64'h00000000FFFFFFFF;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int LEN_W   = 8;
    localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOLD_MODE = 2'd2;

    // Fold modes
    localparam int FOLD_W = 2;
    localparam logic [FOLD_W-1:0] FOLD_32 = 2'd1;
    localparam logic [FOLD_W-1:0] FOLD_24 = 2'd2;

    // Block queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int FIN_ROUNDS = 4;
    localparam int FIN_CNT_W  = $clog2(FIN_ROUNDS);

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } lanes_t;

    // One block to compress; start reloads the lanes from the key,
    // fin runs finalization after the block.
    typedef struct packed {
        logic [WORD_W-1:0] block;
        logic              start;
        logic              fin;
    } blk_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MIX,
        BK_FINAL,
        BK_EMIT
    } back_state_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int s);
        rotl = (x << s) | (x >> (WORD_W - s));
    endfunction

    function automatic lanes_t sip_round(input lanes_t v);
        lanes_t r;
        r = v;
        r.a = r.a + r.b;
        r.b = rotl(r.b, 13);
        r.b = r.b ^ r.a;
        r.a = rotl(r.a, 32);
        r.c = r.c + r.d;
        r.d = rotl(r.d, 16);
        r.d = r.d ^ r.c;
        r.a = r.a + r.d;
        r.d = rotl(r.d, 21);
        r.d = r.d ^ r.a;
        r.c = r.c + r.b;
        r.b = rotl(r.b, 17);
        r.b = r.b ^ r.c;
        r.c = rotl(r.c, 32);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] fold_digest(input logic [WORD_W-1:0] h,
                                                      input logic [FOLD_W-1:0] mode);
        logic [WORD_W-1:0] r;
        case (mode)
            FOLD_32: r = (h ^ (h >> 32)) & MASK32;
            FOLD_24: r = (h ^ (h >> 24) ^ (h >> 48)) & MASK24;
            default: r = h;
        endcase
        return r;
    endfunction

endpackage

/* design/sh24_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_front
// Accepts message words, tracks message length and builds compression blocks.
// ----------------------------------------------------------------------------
module sh24_front
    import sh24_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [WORD_W-1:0]  message_word,
    input  logic [COUNT_W-1:0] byte_count,
    input  logic               last_word,
    input  fifo_stat_t         fifo_stat,
    output logic               push,
    output blk_entry_t         push_entry
);

    logic              in_msg_reg, in_msg_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              pend_reg, pend_next;
    logic [LEN_W-1:0]  pend_len_reg, pend_len_next;
    logic              accept;
    logic [COUNT_W-1:0] cnt_sat;
    logic [LEN_W-1:0]  len_sum;
    logic [WORD_W-1:0] byte_mask;

    assign in_stall = pend_reg || fifo_stat.full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        cnt_sat = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
        len_sum = len_reg + {{(LEN_W-COUNT_W){1'b0}}, cnt_sat};
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            byte_mask[i*8 +: 8] = (i < int'(cnt_sat)) ? 8'hff : 8'h00;
        end
    end

    always_comb
    begin
        in_msg_next   = in_msg_reg;
        len_next      = len_reg;
        pend_next     = pend_reg;
        pend_len_next = pend_len_reg;
        push          = 1'b0;
        push_entry    = '{block: message_word, start: !in_msg_reg, fin: 1'b0};
        if (pend_reg)
        begin
            // trailing length-only block after a full last word
            push_entry = '{block: {pend_len_reg, {(WORD_W-LEN_W){1'b0}}},
                           start: 1'b0, fin: 1'b1};
            if (!fifo_stat.full)
            begin
                push      = 1'b1;
                pend_next = 1'b0;
            end
        end
        else if (accept)
        begin
            push = 1'b1;
            if (!last_word)
            begin
                in_msg_next = 1'b1;
                len_next    = len_reg + LEN_W'(8);
            end
            else
            begin
                in_msg_next = 1'b0;
                len_next    = '0;
                if (cnt_sat == FULL_COUNT)
                begin
                    pend_next     = 1'b1;
                    pend_len_next = len_sum;
                end
                else
                begin
                    push_entry.block = (message_word & byte_mask) |
                                       {len_sum, {(WORD_W-LEN_W){1'b0}}};
                    push_entry.fin   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
            len_reg    <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
            len_reg    <= len_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_len_reg <= pend_len_next;
    end

endmodule

/* design/sh24_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_fifo
// Short register queue of compression blocks between front and back.
// ----------------------------------------------------------------------------
module sh24_fifo
    import sh24_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  blk_entry_t push_entry,
    input  logic       pop,
    output blk_entry_t pop_entry,
    output fifo_stat_t stat
);

    blk_entry_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* design/sh24_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_back
// SipRound engine: compresses queued blocks, finalizes and emits the digest.
// ----------------------------------------------------------------------------
module sh24_back
    import sh24_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [WORD_W-1:0] key_low,
    input  logic [WORD_W-1:0] key_high,
    input  logic [FOLD_W-1:0] fold_mode,
    input  fifo_stat_t        fifo_stat,
    input  blk_entry_t        pop_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [WORD_W-1:0] digest
);

    back_state_t           state_reg, state_next;
    lanes_t                lanes_reg, lanes_next;
    logic [WORD_W-1:0]     m_reg, m_next;
    logic                  fin_reg, fin_next;
    logic [FIN_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     digest_reg, digest_next;
    logic                  out_free;
    lanes_t                base;
    lanes_t                rnd;

    assign out_valid = out_valid_reg;
    assign digest    = digest_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    state_next = BK_MIX;
                end
            end
            BK_MIX:
            begin
                state_next = fin_reg ? BK_FINAL : BK_IDLE;
            end
            BK_FINAL:
            begin
                if (cnt_reg == FIN_CNT_W'(FIN_ROUNDS - 1))
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        base = pop_entry.start ?
               '{a: SIP_C0 ^ key_low, b: SIP_C1 ^ key_high,
                 c: SIP_C2 ^ key_low, d: SIP_C3 ^ key_high} : lanes_reg;
        base.d         = base.d ^ pop_entry.block;
        pop            = 1'b0;
        lanes_next     = lanes_reg;
        m_next         = m_reg;
        fin_next       = fin_reg;
        cnt_next       = cnt_reg;
        digest_next    = digest_reg;
        out_valid_next = out_valid_reg && out_stall;
        // one shared round unit: fed by the fresh block when idle
        rnd            = sip_round((state_reg == BK_IDLE) ? base : lanes_reg);
        case (state_reg)
            BK_IDLE:
            begin
                if (!fifo_stat.empty)
                begin
                    pop        = 1'b1;
                    lanes_next = rnd;
                    m_next     = pop_entry.block;
                    fin_next   = pop_entry.fin;
                end
            end
            BK_MIX:
            begin
                lanes_next   = rnd;
                lanes_next.a = rnd.a ^ m_reg;
                if (fin_reg)
                begin
                    lanes_next.c = rnd.c ^ SIP_FINAL_XOR;
                end
                cnt_next = '0;
            end
            BK_FINAL:
            begin
                lanes_next = rnd;
                cnt_next   = cnt_reg + 1'b1;
            end
            BK_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digest_next    = fold_digest(lanes_reg.a ^ lanes_reg.b ^
                                                 lanes_reg.c ^ lanes_reg.d, fold_mode);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            lanes_reg     <= '0;
            fin_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            lanes_reg     <= lanes_next;
            fin_reg       <= fin_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        digest_reg <= digest_next;
    end

endmodule

/* design/siphash24_stream_hasher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash24_stream_hasher
// Keyed SipHash-2-4 over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// In a steady stream the input rate is set by the back engine, which has a
// single SipRound unit while each compressed block needs two rounds. A last
// word with eight valid bytes produces two blocks (the word and a length-only
// block). After the final block the engine runs four finalization rounds and
// then folds the digest into the output register, waiting while the output
// is stalled; meanwhile the front keeps accepting words of the next message
// into a four-entry block queue. The key is sampled when the first block of a
// message reaches the engine; the fold mode when the digest is emitted. Write
// configuration only while the block is idle.
// ----------------------------------------------------------------------------
module siphash24_stream_hasher
    import sh24_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // input word channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    message_word,
    input  logic [COUNT_W-1:0]   byte_count,
    input  logic                 last_word,
    // digest channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    digest
);

    logic [WORD_W-1:0] key_low_reg;
    logic [WORD_W-1:0] key_high_reg;
    logic [FOLD_W-1:0] fold_mode_reg;

    logic       push;
    logic       pop;
    blk_entry_t push_entry;
    blk_entry_t pop_entry;
    fifo_stat_t fifo_stat;

    // Hold configuration registers; take a write whenever enabled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            fold_mode_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KEY_LOW:   key_low_reg   <= cfg_data;
                CFG_KEY_HIGH:  key_high_reg  <= cfg_data;
                CFG_FOLD_MODE: fold_mode_reg <= cfg_data[FOLD_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: classify words, count length, build blocks.
    sh24_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .fifo_stat    (fifo_stat),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Queue: decouple front and back so each stalls on its own.
    sh24_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (fifo_stat)
    );

    // Back: run SipRounds, finalize, fold and hold the digest.
    sh24_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_low   (key_low_reg),
        .key_high  (key_high_reg),
        .fold_mode (fold_mode_reg),
        .fifo_stat (fifo_stat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .digest    (digest)
    );

    // Never push into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && fifo_stat.full))
        else $error("block pushed into full queue");

    // Never pop an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !fifo_stat.empty)
        else $error("block popped from empty queue");

    // A full last word leaves a length block pending, so input stalls next.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_word && (byte_count >= FULL_COUNT)) |=> in_stall)
        else $error("input not held for trailing length block");

endmodule
